// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define FBU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Delayed check: the consequent must hold after the antecedent.
`define FBU_ASSERT_LATER(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("two-cycle check failed");

// Consequent must hold in the cycle after reset.
`define FBU_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset check failed");

`endif

// ===== rtl/fbu_pkg.sv =====
`default_nettype none

package fbu_pkg;

   localparam int MAX_BOIDS = 1024;
   localparam int IDX_W     = $clog2(MAX_BOIDS);
   localparam int CNT_W     = $clog2(MAX_BOIDS + 1);
   localparam int SUM_W     = 32 + IDX_W;
   localparam int SEP_W     = 34 + IDX_W;
   localparam int ACC_W     = 52;
   localparam int SEP_DIV_STEPS = 33;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEP_WEIGHT,
      CSR_ALIGN_WEIGHT,
      CSR_COHESION_WEIGHT,
      CSR_SEP_RADIUS,
      CSR_VIEW_RADIUS,
      CSR_BOX_HALF_SIDE,
      CSR_SPEED_LIMIT,
      CSR_FLOCK_SIZE
   } csr_index_type;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type [2:0] pos;
      word_type [2:0] vel;
   } boid_type;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/flocking_boid_update.sv =====
`default_nettype none
// Channel    | Handshake             | Payload
// request    | req_valid / req_ready | req_cmd, req_boid_index, req_pos_*, req_vel_*,
//            |                       | req_time_step
// result     | rsp_valid / rsp_ready | rsp_out_index, rsp_new_pos_*, rsp_new_vel_*
// csr write  | csr_we                | csr_index, csr_wdata
//
// An update request walks the boid memory one stored boid at a time and runs the
// bit-serial divider (one quotient bit per cycle) for each separation neighbour and
// for the alignment and cohesion means; its length grows with the flock size and the
// number of separation neighbours.
// Synchronous active-high reset restores the register defaults; the memory holds
// garbage until loaded. A stalled result sits in the output register while the next
// request is already accepted; the block only waits when a second result is ready.

module flocking_boid_update (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_cmd,
   input  wire  [9:0]  req_boid_index,
   input  wire  [31:0] req_pos_x,
   input  wire  [31:0] req_pos_y,
   input  wire  [31:0] req_pos_z,
   input  wire  [31:0] req_vel_x,
   input  wire  [31:0] req_vel_y,
   input  wire  [31:0] req_vel_z,
   input  wire  [15:0] req_time_step,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [9:0]  rsp_out_index,
   output logic [31:0] rsp_new_pos_x,
   output logic [31:0] rsp_new_pos_y,
   output logic [31:0] rsp_new_pos_z,
   output logic [31:0] rsp_new_vel_x,
   output logic [31:0] rsp_new_vel_y,
   output logic [31:0] rsp_new_vel_z,
   input  wire         csr_we,
   input  wire  [fbu_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int IDX_W = fbu_pkg::IDX_W;
   localparam int CNT_W = fbu_pkg::CNT_W;
   localparam int SUM_W = fbu_pkg::SUM_W;
   localparam int SEP_W = fbu_pkg::SEP_W;
   localparam int ACC_W = fbu_pkg::ACC_W;
   localparam int DCNT_W = $clog2(SUM_W);

   typedef enum logic [4:0] {
      S_IDLE, S_SELF, S_PREP_RS, S_PREP_RV, S_PREP_END,
      S_J_ISSUE, S_J_LOAD, S_SQ, S_TEST,
      S_SEP_LOAD, S_SEP_RUN, S_SEP_ACC,
      S_MEAN_LOAD, S_MEAN_RUN, S_MEAN_ACC,
      S_FIN_MUL, S_FIN_ACC, S_WRITE, S_FINISH
   } state_type;

   typedef enum logic [2:0] {FS_SEP, FS_ALI, FS_COH, FS_VEL, FS_POS} fin_step_type;

   // control
   state_type    state_ff, state_in;
   fin_step_type step_ff, step_in;
   logic [1:0]   axis_ff, axis_in;
   logic         kind_ff, kind_in;
   logic [CNT_W-1:0] n_ff, n_in, j_ff, j_in, k_ff, k_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // configuration
   logic signed [31:0] sep_weight_ff, sep_weight_in;
   logic signed [31:0] align_weight_ff, align_weight_in;
   logic signed [31:0] cohesion_weight_ff, cohesion_weight_in;
   logic [30:0] sep_radius_ff, sep_radius_in, view_radius_ff, view_radius_in;
   logic [30:0] box_half_side_ff, box_half_side_in, speed_limit_ff, speed_limit_in;
   logic [10:0] flock_size_ff, flock_size_in;

   // datapath
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [9:0]         bi_ff, bi_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] p_ff [3], p_in [3], v_ff [3], v_in [3];
   fbu_pkg::boid_type  nb_ff, nb_in;
   logic [30:0]        dmag_ff [3], dmag_in [3];
   logic [2:0]         dneg_ff, dneg_in;
   logic [63:0]        d2_ff, d2_in, rs2_ff, rs2_in, rv2_ff, rv2_in;
   logic signed [SEP_W-1:0] sep_ff [3], sep_in [3];
   logic signed [SUM_W-1:0] vsum_ff [3], vsum_in [3], psum_ff [3], psum_in [3];
   logic signed [31:0] ali_ff [3], ali_in [3], coh_ff [3], coh_in [3];
   logic signed [ACC_W-1:0] accsum_ff, accsum_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;
   logic [63:0]        rem_ff, rem_in, numsh_ff, numsh_in, den_ff, den_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic               qneg_ff, qneg_in;
   logic [9:0]         rsp_index_ff, rsp_index_in;
   logic [31:0]        rsp_pos_ff [3], rsp_pos_in [3], rsp_vel_ff [3], rsp_vel_in [3];

   // boid memory
   fbu_pkg::boid_type mem [fbu_pkg::MAX_BOIDS];
   fbu_pkg::boid_type rd_data_ff, mem_wd;
   logic [IDX_W-1:0]  rd_addr, mem_wa;
   logic              mem_we;

   // shared divider step
   logic [64:0] div_trial, div_diff;
   logic        div_ge;
   logic signed [49:0] prod_sh;

   assign div_trial = {rem_ff, numsh_ff[63]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_ge    = div_trial >= {1'b0, den_ff};
   assign prod_sh   = prod_ff[65:16];

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_new_vel_x = rsp_vel_ff[0];
   assign rsp_new_vel_y = rsp_vel_ff[1];
   assign rsp_new_vel_z = rsp_vel_ff[2];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      logic               adv;
      logic               far;
      logic signed [32:0] dd [3];
      logic [32:0]        dm [3];
      logic signed [SUM_W-1:0] s;
      logic [SUM_W-1:0]   smag;
      logic signed [63:0] qs;
      logic signed [35:0] nv, np, lim36, box36;

      adv = 1'b0;
      far = 1'b0;
      s = '0;
      smag = '0;
      qs = '0;
      nv = '0;
      np = '0;
      lim36 = $signed(36'(speed_limit_ff));
      box36 = $signed(36'(box_half_side_ff));
      for (int a = 0; a < 3; a++) begin
         dd[a] = 33'(p_ff[a]) - 33'($signed(rd_data_ff.pos[a]));
         dm[a] = dd[a][32] ? 33'(-dd[a]) : 33'(dd[a]);
         far = far | dm[a][32] | dm[a][31];
      end

      state_in = state_ff;
      step_in = step_ff;
      axis_in = axis_ff;
      kind_in = kind_ff;
      n_in = n_ff;
      j_in = j_ff;
      k_in = k_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sep_weight_in = sep_weight_ff;
      align_weight_in = align_weight_ff;
      cohesion_weight_in = cohesion_weight_ff;
      sep_radius_in = sep_radius_ff;
      view_radius_in = view_radius_ff;
      box_half_side_in = box_half_side_ff;
      speed_limit_in = speed_limit_ff;
      flock_size_in = flock_size_ff;
      idx_in = idx_ff;
      bi_in = bi_ff;
      dt_in = dt_ff;
      p_in = p_ff;
      v_in = v_ff;
      nb_in = nb_ff;
      dmag_in = dmag_ff;
      dneg_in = dneg_ff;
      d2_in = d2_ff;
      rs2_in = rs2_ff;
      rv2_in = rv2_ff;
      sep_in = sep_ff;
      vsum_in = vsum_ff;
      psum_in = psum_ff;
      ali_in = ali_ff;
      coh_in = coh_ff;
      accsum_in = accsum_ff;
      rem_in = rem_ff;
      numsh_in = numsh_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      qneg_in = qneg_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;
      mul_a = '0;
      mul_b = '0;
      rd_addr = j_ff[IDX_W-1:0];
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = {p_ff[0], p_ff[1], p_ff[2], v_ff[0], v_ff[1], v_ff[2]};
      mem_wd.pos[0] = p_ff[0];
      mem_wd.pos[1] = p_ff[1];
      mem_wd.pos[2] = p_ff[2];
      mem_wd.vel[0] = v_ff[0];
      mem_wd.vel[1] = v_ff[1];
      mem_wd.vel[2] = v_ff[2];

      // configuration writes, taken in any state
      if (csr_we) begin
         unique case (csr_index)
            fbu_pkg::CSR_SEP_WEIGHT:      sep_weight_in = csr_wdata;
            fbu_pkg::CSR_ALIGN_WEIGHT:    align_weight_in = csr_wdata;
            fbu_pkg::CSR_COHESION_WEIGHT: cohesion_weight_in = csr_wdata;
            fbu_pkg::CSR_SEP_RADIUS:      sep_radius_in = csr_wdata[30:0];
            fbu_pkg::CSR_VIEW_RADIUS:     view_radius_in = csr_wdata[30:0];
            fbu_pkg::CSR_BOX_HALF_SIDE:   box_half_side_in = csr_wdata[30:0];
            fbu_pkg::CSR_SPEED_LIMIT:     speed_limit_in = csr_wdata[30:0];
            fbu_pkg::CSR_FLOCK_SIZE:      flock_size_in = csr_wdata[10:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = IDX_W'(req_boid_index);
            if (req_valid) begin
               bi_in = req_boid_index;
               idx_in = IDX_W'(req_boid_index);
               dt_in = req_time_step;
               j_in = '0;
               if (req_cmd) begin
                  state_in = S_SELF;
               end else begin
                  // write the boid straight into the store and echo it
                  mem_we = 1'b1;
                  mem_wa = IDX_W'(req_boid_index);
                  mem_wd.pos[0] = req_pos_x;
                  mem_wd.pos[1] = req_pos_y;
                  mem_wd.pos[2] = req_pos_z;
                  mem_wd.vel[0] = req_vel_x;
                  mem_wd.vel[1] = req_vel_y;
                  mem_wd.vel[2] = req_vel_z;
                  p_in[0] = req_pos_x;
                  p_in[1] = req_pos_y;
                  p_in[2] = req_pos_z;
                  v_in[0] = req_vel_x;
                  v_in[1] = req_vel_y;
                  v_in[2] = req_vel_z;
                  state_in = S_FINISH;
               end
            end
         end
         S_SELF: begin
            for (int a = 0; a < 3; a++) begin
               p_in[a] = rd_data_ff.pos[a];
               v_in[a] = rd_data_ff.vel[a];
               sep_in[a] = '0;
               vsum_in[a] = '0;
               psum_in[a] = '0;
            end
            k_in = '0;
            if (int'(flock_size_ff) > fbu_pkg::MAX_BOIDS) begin
               n_in = CNT_W'(fbu_pkg::MAX_BOIDS);
            end else begin
               n_in = CNT_W'(flock_size_ff);
            end
            state_in = S_PREP_RS;
         end
         S_PREP_RS: begin
            mul_a = $signed(33'(sep_radius_ff));
            mul_b = $signed(33'(sep_radius_ff));
            state_in = S_PREP_RV;
         end
         S_PREP_RV: begin
            rs2_in = prod_ff[63:0];
            mul_a = $signed(33'(view_radius_ff));
            mul_b = $signed(33'(view_radius_ff));
            state_in = S_PREP_END;
         end
         S_PREP_END: begin
            rv2_in = prod_ff[63:0];
            if (n_ff == '0) begin
               axis_in = '0;
               kind_in = 1'b0;
               state_in = S_MEAN_LOAD;
            end else begin
               state_in = S_J_ISSUE;
            end
         end
         S_J_ISSUE: begin
            state_in = S_J_LOAD;
         end
         S_J_LOAD: begin
            // drop the boid itself and pairs too far apart on any axis
            if (j_ff[IDX_W-1:0] == idx_ff || far) begin
               adv = 1'b1;
            end else begin
               for (int a = 0; a < 3; a++) begin
                  dmag_in[a] = dm[a][30:0];
                  dneg_in[a] = dd[a][32];
               end
               nb_in = rd_data_ff;
               d2_in = '0;
               axis_in = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (axis_ff != 2'd3) begin
               mul_a = $signed(33'(dmag_ff[axis_ff]));
               mul_b = $signed(33'(dmag_ff[axis_ff]));
            end
            if (axis_ff != 2'd0) begin
               d2_in = d2_ff + prod_ff[63:0];
            end
            if (axis_ff == 2'd3) begin
               axis_in = '0;
               state_in = S_TEST;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_TEST: begin
            if (d2_ff == '0) begin
               adv = 1'b1;
            end else begin
               if (d2_ff < rv2_ff) begin
                  for (int a = 0; a < 3; a++) begin
                     vsum_in[a] = vsum_ff[a] + SUM_W'($signed(nb_ff.vel[a]));
                     psum_in[a] = psum_ff[a] + SUM_W'($signed(nb_ff.pos[a]));
                  end
                  k_in = k_ff + CNT_W'(1);
               end
               if (d2_ff < rs2_ff) begin
                  axis_in = '0;
                  state_in = S_SEP_LOAD;
               end else begin
                  adv = 1'b1;
               end
            end
         end
         S_SEP_LOAD: begin
            // |d| * 2^32 / d2; the top bits already sit below d2
            rem_in = 64'(dmag_ff[axis_ff] >> 1);
            numsh_in = {dmag_ff[axis_ff][0], 63'b0};
            den_in = d2_ff;
            quo_in = '0;
            qneg_in = dneg_ff[axis_ff];
            dcnt_in = DCNT_W'(fbu_pkg::SEP_DIV_STEPS - 1);
            state_in = S_SEP_RUN;
         end
         S_SEP_RUN, S_MEAN_RUN: begin
            rem_in = div_ge ? div_diff[63:0] : div_trial[63:0];
            numsh_in = {numsh_ff[62:0], 1'b0};
            quo_in = {quo_ff[SUM_W-2:0], div_ge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) begin
               state_in = (state_ff == S_SEP_RUN) ? S_SEP_ACC : S_MEAN_ACC;
            end
         end
         S_SEP_ACC: begin
            if (qneg_ff) begin
               sep_in[axis_ff] = sep_ff[axis_ff] - $signed(SEP_W'(quo_ff));
            end else begin
               sep_in[axis_ff] = sep_ff[axis_ff] + $signed(SEP_W'(quo_ff));
            end
            if (axis_ff == 2'd2) begin
               adv = 1'b1;
            end else begin
               axis_in = axis_ff + 2'd1;
               state_in = S_SEP_LOAD;
            end
         end
         S_MEAN_LOAD: begin
            if (k_ff == '0) begin
               // no neighbours in view: alignment and cohesion vanish
               for (int a = 0; a < 3; a++) begin
                  ali_in[a] = '0;
                  coh_in[a] = '0;
               end
               axis_in = '0;
               step_in = FS_SEP;
               state_in = S_FIN_MUL;
            end else begin
               s = kind_ff ? psum_ff[axis_ff] : vsum_ff[axis_ff];
               smag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
               rem_in = '0;
               numsh_in = {smag, {(64 - SUM_W){1'b0}}};
               den_in = 64'(k_ff);
               quo_in = '0;
               qneg_in = s[SUM_W-1];
               dcnt_in = DCNT_W'(SUM_W - 1);
               state_in = S_MEAN_RUN;
            end
         end
         S_MEAN_ACC: begin
            qs = $signed(64'(quo_ff));
            if (qneg_ff) begin
               qs = -qs;
            end
            if (kind_ff) begin
               coh_in[axis_ff] = fbu_pkg::sat32(qs - 64'(p_ff[axis_ff]));
            end else begin
               ali_in[axis_ff] = fbu_pkg::sat32(qs - 64'(v_ff[axis_ff]));
            end
            if (axis_ff == 2'd2) begin
               axis_in = '0;
               if (kind_ff) begin
                  step_in = FS_SEP;
                  state_in = S_FIN_MUL;
               end else begin
                  kind_in = 1'b1;
                  state_in = S_MEAN_LOAD;
               end
            end else begin
               axis_in = axis_ff + 2'd1;
               state_in = S_MEAN_LOAD;
            end
         end
         S_FIN_MUL: begin
            unique case (step_ff)
               FS_SEP: begin
                  mul_a = 33'(fbu_pkg::sat32(64'(sep_ff[axis_ff])));
                  mul_b = 33'(sep_weight_ff);
               end
               FS_ALI: begin
                  mul_a = 33'(ali_ff[axis_ff]);
                  mul_b = 33'(align_weight_ff);
               end
               FS_COH: begin
                  mul_a = 33'(coh_ff[axis_ff]);
                  mul_b = 33'(cohesion_weight_ff);
               end
               FS_VEL: begin
                  mul_a = 33'(fbu_pkg::sat32(64'(accsum_ff)));
                  mul_b = $signed({17'b0, dt_ff});
               end
               FS_POS: begin
                  mul_a = 33'(v_ff[axis_ff]);
                  mul_b = $signed({17'b0, dt_ff});
               end
               default: ;
            endcase
            state_in = S_FIN_ACC;
         end
         S_FIN_ACC: begin
            state_in = S_FIN_MUL;
            unique case (step_ff)
               FS_SEP: begin
                  accsum_in = ACC_W'(prod_sh);
                  step_in = FS_ALI;
               end
               FS_ALI: begin
                  accsum_in = accsum_ff + ACC_W'(prod_sh);
                  step_in = FS_COH;
               end
               FS_COH: begin
                  accsum_in = accsum_ff + ACC_W'(prod_sh);
                  step_in = FS_VEL;
               end
               FS_VEL: begin
                  // integrate velocity, clamp per axis
                  nv = 36'(v_ff[axis_ff]) + 36'(prod_sh);
                  if (nv > lim36) begin
                     nv = lim36;
                  end
                  if (nv < -lim36) begin
                     nv = -lim36;
                  end
                  v_in[axis_ff] = nv[31:0];
                  step_in = FS_POS;
               end
               FS_POS: begin
                  // integrate position, wrap once each way, saturate
                  np = 36'(p_ff[axis_ff]) + 36'(prod_sh);
                  if (np < -box36) begin
                     np = np + (box36 <<< 1);
                  end
                  if (np > box36) begin
                     np = np - (box36 <<< 1);
                  end
                  p_in[axis_ff] = fbu_pkg::sat32(64'(np));
                  step_in = FS_SEP;
                  if (axis_ff == 2'd2) begin
                     axis_in = '0;
                     state_in = S_WRITE;
                  end else begin
                     axis_in = axis_ff + 2'd1;
                  end
               end
               default: ;
            endcase
         end
         S_WRITE: begin
            mem_we = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = bi_ff;
               for (int a = 0; a < 3; a++) begin
                  rsp_pos_in[a] = p_ff[a];
                  rsp_vel_in[a] = v_ff[a];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // advance the walk to the next stored boid
      if (adv) begin
         j_in = j_ff + CNT_W'(1);
         if (j_ff + CNT_W'(1) == n_ff) begin
            axis_in = '0;
            kind_in = 1'b0;
            state_in = S_MEAN_LOAD;
         end else begin
            state_in = S_J_ISSUE;
         end
      end
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      step_ff <= step_in;
      axis_ff <= axis_in;
      kind_ff <= kind_in;
      n_ff <= n_in;
      j_ff <= j_in;
      k_ff <= k_in;
      dcnt_ff <= dcnt_in;
      rsp_valid_ff <= rsp_valid_in;
      sep_weight_ff <= sep_weight_in;
      align_weight_ff <= align_weight_in;
      cohesion_weight_ff <= cohesion_weight_in;
      sep_radius_ff <= sep_radius_in;
      view_radius_ff <= view_radius_in;
      box_half_side_ff <= box_half_side_in;
      speed_limit_ff <= speed_limit_in;
      flock_size_ff <= flock_size_in;
      idx_ff <= idx_in;
      bi_ff <= bi_in;
      dt_ff <= dt_in;
      p_ff <= p_in;
      v_ff <= v_in;
      nb_ff <= nb_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      d2_ff <= d2_in;
      rs2_ff <= rs2_in;
      rv2_ff <= rv2_in;
      sep_ff <= sep_in;
      vsum_ff <= vsum_in;
      psum_ff <= psum_in;
      ali_ff <= ali_in;
      coh_ff <= coh_in;
      accsum_ff <= accsum_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      numsh_ff <= numsh_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      qneg_ff <= qneg_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= FS_SEP;
         axis_ff <= '0;
         kind_ff <= 1'b0;
         j_ff <= '0;
         k_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sep_weight_ff <= 32'sd360448;
         align_weight_ff <= 32'sd65536;
         cohesion_weight_ff <= 32'sd65536;
         sep_radius_ff <= 31'd2621440;
         view_radius_ff <= 31'd3276800;
         box_half_side_ff <= 31'd13107200;
         speed_limit_ff <= 31'd13107200;
         flock_size_ff <= 11'd600;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fbu_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module fbu_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       req_cmd,
   input wire [9:0] req_boid_index,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [9:0] rsp_out_index
);

   `FBU_ASSERT_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)
   `FBU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `FBU_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_index))
   `FBU_ASSERT_LATER(a_load_echo, clock, reset, req_valid && req_ready && !req_cmd && !rsp_valid, rsp_valid && rsp_out_index == $past(req_boid_index, 2))

endmodule

bind flocking_boid_update fbu_checker u_fbu_checker (.*);

`default_nettype wire

// ===== tb/sv/boid_checker.sv =====
`timescale 1ns / 100ps

module boid_checker
   import fbu_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire         req_cmd,
   input  wire  [9:0]  req_boid_index,
   input  wire  [31:0] req_pos_x,
   input  wire  [31:0] req_pos_y,
   input  wire  [31:0] req_pos_z,
   input  wire  [31:0] req_vel_x,
   input  wire  [31:0] req_vel_y,
   input  wire  [31:0] req_vel_z,
   input  wire  [15:0] req_time_step,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [9:0]  rsp_out_index,
   input  wire  [31:0] rsp_new_pos_x,
   input  wire  [31:0] rsp_new_pos_y,
   input  wire  [31:0] rsp_new_pos_z,
   input  wire  [31:0] rsp_new_vel_x,
   input  wire  [31:0] rsp_new_vel_y,
   input  wire  [31:0] rsp_new_vel_z,
   input  wire         csr_we,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [31:0] csr_wdata,
   output int          fail_count,
   output int          boids_in_flight
);

   typedef struct {
      logic [9:0]  index;
      logic [31:0] pos [3];
      logic [31:0] vel [3];
   } boid_echo_t;

   logic signed [31:0] pos_mem [3][MAX_BOIDS];
   logic signed [31:0] vel_mem [3][MAX_BOIDS];
   logic signed [31:0] w_sep, w_align, w_coh;
   logic [30:0] r_sep, r_view, box_half, speed_max;
   logic [10:0] flock_n;
   boid_echo_t  boids_due [$];

   function automatic longint unsigned mag(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Apply one request to the shadow flock and return the stored boid after it.
   function automatic boid_echo_t flock_step(input logic cmd, input logic [9:0] bi,
                                             input logic [31:0] ip [3],
                                             input logic [31:0] iv [3],
                                             input logic [15:0] dt);
      longint p [3], v [3], d [3], sep [3], vsum [3], psum [3];
      longint k, ali, coh, acc, nv, np, lim, box, dts;
      longint unsigned d2, rs2, rv2, t, ru;
      int n;
      bit far;
      boid_echo_t r;
      if (!cmd) begin
         for (int a = 0; a < 3; a++) begin
            pos_mem[a][bi] = ip[a];
            vel_mem[a][bi] = iv[a];
         end
      end else begin
         n = (flock_n > MAX_BOIDS) ? MAX_BOIDS : flock_n;
         ru = r_sep;
         rs2 = ru * ru;
         ru = r_view;
         rv2 = ru * ru;
         lim = speed_max;
         box = box_half;
         dts = dt;
         k = 0;
         for (int a = 0; a < 3; a++) begin
            p[a] = pos_mem[a][bi];
            v[a] = vel_mem[a][bi];
            sep[a] = 0;
            vsum[a] = 0;
            psum[a] = 0;
         end
         for (int j = 0; j < n; j++) begin
            if (j == bi) continue;
            far = 0;
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
               d[a] = p[a] - longint'(pos_mem[a][j]);
               if (mag(d[a]) >= 64'h8000_0000) far = 1;
            end
            if (far) continue;
            for (int a = 0; a < 3; a++) d2 += mag(d[a]) * mag(d[a]);
            if (d2 == 0) continue;
            if (d2 < rs2) begin
               for (int a = 0; a < 3; a++) begin
                  t = (mag(d[a]) << 32) / d2;
                  sep[a] += (d[a] < 0) ? -longint'(t) : longint'(t);
               end
            end
            if (d2 < rv2) begin
               for (int a = 0; a < 3; a++) begin
                  vsum[a] += longint'(vel_mem[a][j]);
                  psum[a] += longint'(pos_mem[a][j]);
               end
               k++;
            end
         end
         for (int a = 0; a < 3; a++) begin
            ali = (k != 0) ? vsum[a] / k - v[a] : 0;
            coh = (k != 0) ? psum[a] / k - p[a] : 0;
            acc = ((clip32(sep[a]) * longint'(w_sep)) >>> 16)
                + ((clip32(ali) * longint'(w_align)) >>> 16)
                + ((clip32(coh) * longint'(w_coh)) >>> 16);
            acc = clip32(acc);
            nv = v[a] + ((acc * dts) >>> 16);
            if (nv > lim) nv = lim;
            if (nv < -lim) nv = -lim;
            np = p[a] + ((nv * dts) >>> 16);
            if (np < -box) np += 2 * box;
            if (np > box) np -= 2 * box;
            np = clip32(np);
            vel_mem[a][bi] = nv[31:0];
            pos_mem[a][bi] = np[31:0];
         end
      end
      r.index = bi;
      for (int a = 0; a < 3; a++) begin
         r.pos[a] = pos_mem[a][bi];
         r.vel[a] = vel_mem[a][bi];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   initial boids_in_flight = 0;

   always @(posedge clock) begin
      logic [31:0] ip [3];
      logic [31:0] iv [3];
      logic [31:0] gp [3];
      logic [31:0] gv [3];
      boid_echo_t  want;
      if (reset) begin
         w_sep = 32'sd360448;
         w_align = 32'sd65536;
         w_coh = 32'sd65536;
         r_sep = 31'd2621440;
         r_view = 31'd3276800;
         box_half = 31'd13107200;
         speed_max = 31'd13107200;
         flock_n = 11'd600;
         boids_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SEP_WEIGHT:      w_sep = csr_wdata;
               CSR_ALIGN_WEIGHT:    w_align = csr_wdata;
               CSR_COHESION_WEIGHT: w_coh = csr_wdata;
               CSR_SEP_RADIUS:      r_sep = csr_wdata[30:0];
               CSR_VIEW_RADIUS:     r_view = csr_wdata[30:0];
               CSR_BOX_HALF_SIDE:   box_half = csr_wdata[30:0];
               CSR_SPEED_LIMIT:     speed_max = csr_wdata[30:0];
               CSR_FLOCK_SIZE:      flock_n = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (boids_due.size() == 0) begin
               report_mismatch("unexpected result", {22'b0, rsp_out_index}, 32'b0);
            end else begin
               want = boids_due.pop_front();
               gp = '{rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z};
               gv = '{rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z};
               if (rsp_out_index !== want.index)
                  report_mismatch("out_index", {22'b0, rsp_out_index}, {22'b0, want.index});
               for (int a = 0; a < 3; a++) begin
                  if (gp[a] !== want.pos[a])
                     report_mismatch($sformatf("new_pos[%0d]", a), gp[a], want.pos[a]);
                  if (gv[a] !== want.vel[a])
                     report_mismatch($sformatf("new_vel[%0d]", a), gv[a], want.vel[a]);
               end
            end
         end
         if (req_valid && req_ready) begin
            ip = '{req_pos_x, req_pos_y, req_pos_z};
            iv = '{req_vel_x, req_vel_y, req_vel_z};
            boids_due.push_back(flock_step(req_cmd, req_boid_index, ip, iv, req_time_step));
         end
      end
      boids_in_flight = boids_due.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import fbu_pkg::*;

   localparam int STALL_LIMIT = 300000;
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   wire         req_ready;
   logic        req_cmd = 0;
   logic [9:0]  req_boid_index = 0;
   logic [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [31:0] req_vel_x = 0, req_vel_y = 0, req_vel_z = 0;
   logic [15:0] req_time_step = 0;
   wire         rsp_valid;
   logic        rsp_ready = 0;
   wire  [9:0]  rsp_out_index;
   wire  [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   wire  [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic        csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0] csr_wdata = 0;
   int          fail_count;
   int          boids_in_flight;

   // Percent chance per cycle that the sender holds off / the receiver stalls.
   int          send_idle = 0;
   int          recv_idle = 0;
   int          quiet_cycles = 0;
   bit          loaded [MAX_BOIDS];

   flocking_boid_update DUT (.*);
   boid_checker checker_i (.*);

   always #5 clock = ~clock;

   // Randomize the result-side backpressure every cycle.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   // Watchdog: end the run if nothing is handed over for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Issue one request; hold valid and payload until the handshake completes.
   // Valid is only dropped at the start of a gap, never right before a raise.
   task automatic send_request(input logic cmd, input logic [9:0] idx,
                               input logic [31:0] px, py, pz, vx, vy, vz,
                               input logic [15:0] dt);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid      <= 1;
      req_cmd        <= cmd;
      req_boid_index <= idx;
      req_pos_x <= px;  req_pos_y <= py;  req_pos_z <= pz;
      req_vel_x <= vx;  req_vel_y <= vy;  req_vel_z <= vz;
      req_time_step  <= dt;
      do @(posedge clock); while (!req_ready);
      if (cmd == REQ_LOAD) loaded[idx] = 1;
   endtask

   // Load a boid: mostly clustered so that neighbour rules fire, sometimes any bit pattern.
   task automatic load_boid(input logic [9:0] idx, input bit spread);
      logic [31:0] f [6];
      for (int i = 0; i < 6; i++) begin
         if (spread || $urandom_range(99) < 20) f[i] = $urandom;
         else if (i < 3) f[i] = $urandom_range(0, 120 << 16) - (60 << 16);
         else f[i] = $urandom_range(0, 40 << 16) - (20 << 16);
      end
      send_request(REQ_LOAD, idx, f[0], f[1], f[2], f[3], f[4], f[5], $urandom);
   endtask

   task automatic update_boid(input logic [9:0] idx, input logic [15:0] dt);
      send_request(REQ_UPDATE, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, dt);
   endtask

   // Drain: hold off until every result is back, then let the block settle.
   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (boids_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] data);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_flock(input logic [31:0] sw, aw, cw, sr, vr, bx, sl,
                                input int n);
      csr_write(CSR_SEP_WEIGHT, sw);
      csr_write(CSR_ALIGN_WEIGHT, aw);
      csr_write(CSR_COHESION_WEIGHT, cw);
      csr_write(CSR_SEP_RADIUS, sr);
      csr_write(CSR_VIEW_RADIUS, vr);
      csr_write(CSR_BOX_HALF_SIDE, bx);
      csr_write(CSR_SPEED_LIMIT, sl);
      csr_write(CSR_FLOCK_SIZE, n);
      csr_we <= 0;
   endtask

   // Fill the flock, then mix loads and updates over the flock and a few boids past it.
   // Updates only touch loaded boids, and the whole flock is loaded first.
   task automatic run_phase(input int s_idle, r_idle, n, count);
      int top;
      logic [9:0] idx;
      send_idle = s_idle;
      recv_idle = r_idle;
      top = (n + 3 > MAX_BOIDS - 1) ? MAX_BOIDS - 1 : n + 3;
      for (int i = 0; i < n; i++) load_boid(i, 0);
      for (int i = 0; i < count; i++) begin
         idx = $urandom_range(0, top);
         if ($urandom_range(99) < 35 || !loaded[idx]) load_boid(idx, 0);
         else update_boid(idx, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset defaults, small flock, corner cases.
      program_flock(32'd360448, 32'd65536, 32'd65536, 32'd2621440, 32'd3276800,
                    32'd13107200, 32'd13107200, 8);
      send_request(REQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
      // near neighbour on x
      send_request(REQ_LOAD, 1, 1 << 16, 0, 0, 2 << 16, 0, 0, 0);
      // same place as boid 0: zero distance, skipped
      send_request(REQ_LOAD, 2, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0);
      // axis difference of 2^31 or more: excluded
      send_request(REQ_LOAD, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 16'hFFFF);
      send_request(REQ_LOAD, 4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   0, 0, 0, 16'hFFFF);
      // velocities beyond the clamp
      send_request(REQ_LOAD, 5, 3 << 16, 1 << 16, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 0);
      send_request(REQ_LOAD, 6, 32'hFFFE_0000, 0, 2 << 16, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_request(REQ_LOAD, 7, 3 << 16, 32'hFFFE_0000, 5 << 16, 1 << 16, 1 << 16, 0, 0);
      update_boid(0, 16'hFFFF);
      update_boid(0, 0);
      update_boid(5, 16'hFFFF);
      update_boid(3, 16'hFFFF);
      update_boid(4, 16'hFFFF);
      update_boid(6, 16'hFFFF);
      update_boid(1, 16'h8000);
      update_boid(7, 16'h0001);
      // boids outside the flock still update from it
      send_request(REQ_LOAD, 9, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 0);
      update_boid(9, 16'hFFFF);
      send_request(REQ_LOAD, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      update_boid(1023, 16'hFFFF);
      drain_results();

      // Random weights and radii, sender gaps.
      program_flock($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 18),
                    $urandom_range(0, 1 << 18), $urandom_range(1 << 20, 40 << 16),
                    $urandom_range(1 << 20, 80 << 16), $urandom_range(1 << 20, 300 << 16),
                    $urandom_range(1 << 16, 300 << 16), 12);
      run_phase(70, 0, 12, 35);
      drain_results();

      // Largest positive extremes, single-boid flock, receiver stalls.
      program_flock(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      run_phase(0, 70, 1, 30);
      drain_results();

      // Most negative weights, zero radii, zero box and clamp, both sides idle.
      program_flock(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 6);
      run_phase(30, 30, 6, 30);
      drain_results();

      // Full store walk: load every entry spread out, then a couple of updates.
      program_flock(32'd360448, 32'd65536, 32'd65536, 32'd2621440, 32'd3276800,
                    32'd13107200, 32'd13107200, MAX_BOIDS);
      send_idle = 0;
      recv_idle = 0;
      for (int i = 0; i < MAX_BOIDS; i++) load_boid(i, 1);
      send_idle = 30;
      recv_idle = 30;
      update_boid($urandom_range(0, MAX_BOIDS - 1), $urandom);
      update_boid($urandom_range(0, MAX_BOIDS - 1), $urandom);
      drain_results();
      repeat (50) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
